// File: hw/rtl/rmc_pkg.sv
package rmc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FIRST_PRIME     = 2'd0;
  localparam logic [1:0] CFG_SECOND_PRIME    = 2'd1;
  localparam logic [1:0] CFG_PUBLIC_EXPONENT = 2'd2;

  // item kinds
  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  // control of the shared add / reduce unit
  typedef struct packed {
    logic neg;     // use (m - y) instead of y
    logic cin;     // carry in
    logic reduce;  // conditional subtract of m
  } rmc_alu_ctl_t;

endpackage

// File: hw/rtl/rsa_modexp_cipher_core.sv
// Textbook RSA engine for small keys. Program first_prime (index 0),
// second_prime (index 1) and public_exponent (index 2) over the cfg port while
// the block is idle; primes keep their low PRIME_BITS bits. Each input item
// (kind 0 = encrypt, 1 = decrypt) yields one result item: (data mod n)^x mod n
// with n = p*q and x = e, or x = d = e^-1 mod (p-1)(q-1) for decrypt. If the
// inverse does not exist (or phi is 0) a decrypt returns 0 with key_error set;
// n = 0 returns 0. All arithmetic runs on a single W-bit add/compare/subtract
// unit (W = max(32, 2*PRIME_BITS)) driven by a small sequencer, so the block
// takes one item at a time and in_ready is low while busy. An item first
// forms n and phi, then reduces the data, then per exponent bit runs one
// modular square (bit-serial shift-add) plus a modular multiply when the
// bit is set; with n = 0 the reduction and the exponent loop are skipped.
// Decrypt adds the extended Euclid pass: per quotient step one restoring
// division and one modular multiply, at most ~1.5*W steps. The result
// register frees the core as soon as the item is handed off.
module rsa_modexp_cipher_core #(
  parameter int PRIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_data_word,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_word,
  output logic        out_key_error
);

  localparam int W  = (2 * PRIME_BITS > 32) ? 2 * PRIME_BITS : 32;
  localparam int CW = $clog2(W + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_N_GO       = 5'd1;
  localparam logic [4:0] S_N_END      = 5'd2;
  localparam logic [4:0] S_PHI_END    = 5'd3;
  localparam logic [4:0] S_EMOD_END   = 5'd4;
  localparam logic [4:0] S_EU_TEST    = 5'd5;
  localparam logic [4:0] S_EU_Q       = 5'd6;
  localparam logic [4:0] S_EU_T       = 5'd7;
  localparam logic [4:0] S_RED        = 5'd8;
  localparam logic [4:0] S_RED_END    = 5'd9;
  localparam logic [4:0] S_PW_SQ      = 5'd10;
  localparam logic [4:0] S_PW_SQ_END  = 5'd11;
  localparam logic [4:0] S_PW_MUL_END = 5'd12;
  localparam logic [4:0] S_PW_NEXT    = 5'd13;
  localparam logic [4:0] S_FIN        = 5'd14;
  localparam logic [4:0] S_MUL        = 5'd15;
  localparam logic [4:0] S_DIV        = 5'd16;

  // configuration registers
  logic [PRIME_BITS-1:0] p_r, q_r;
  logic [31:0]           e_r;

  // control
  logic [4:0]  state_r, state_nxt;
  logic [4:0]  ret_r, ret_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ecnt_r, ecnt_nxt;
  logic        ph_r, ph_nxt;
  logic        plain_r, plain_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] opa_r, opa_nxt;
  logic [W-1:0] opb_r, opb_nxt;
  logic [W-1:0] md_r, md_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] n_r, n_nxt;
  logic [W-1:0] phi_r, phi_nxt;
  logic [W-1:0] r0_r, r0_nxt;
  logic [W-1:0] r1_r, r1_nxt;
  logic [W-1:0] t0_r, t0_nxt;
  logic [W-1:0] t1_r, t1_nxt;
  logic [W-1:0] ex_r, ex_nxt;
  logic [W-1:0] base_r, base_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         kind_r, kind_nxt;
  logic         err_r, err_nxt;
  logic [31:0]  out_result_r, out_result_nxt;
  logic         out_err_r, out_err_nxt;

  // shared unit
  logic [W-1:0]          alu_x, alu_y, alu_m, alu_res;
  rmc_pkg::rmc_alu_ctl_t alu_ctl;
  logic                  alu_ge;

  logic [PRIME_BITS-1:0] pm, qm;

  rmc_alu #(.W(W)) u_alu (
    .x   (alu_x),
    .y   (alu_y),
    .m   (alu_m),
    .ctl (alu_ctl),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_word = out_result_r;
  assign out_key_error   = out_err_r;

  // p-1, q-1 saturate at zero
  assign pm = (p_r == '0) ? '0 : p_r - PRIME_BITS'(1);
  assign qm = (q_r == '0) ? '0 : q_r - PRIME_BITS'(1);

  // operand steering for the shared unit
  always_comb begin
    alu_x   = acc_r;
    alu_y   = acc_r;
    alu_m   = md_r;
    alu_ctl = '0;
    case (state_r)
      S_MUL: begin
        alu_ctl.reduce = !plain_r;
        if (ph_r) begin
          alu_y = opa_r;
        end
      end
      S_DIV: begin
        alu_ctl.reduce = 1'b1;
        alu_ctl.cin    = opb_r[W-1];
      end
      S_EU_T: begin
        // t0 - q*t1 mod phi
        alu_x          = t0_r;
        alu_m          = phi_r;
        alu_ctl.neg    = 1'b1;
        alu_ctl.reduce = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    cnt_nxt        = cnt_r;
    ecnt_nxt       = ecnt_r;
    ph_nxt         = ph_r;
    plain_nxt      = plain_r;
    acc_nxt        = acc_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    md_nxt         = md_r;
    quo_nxt        = quo_r;
    n_nxt          = n_r;
    phi_nxt        = phi_r;
    r0_nxt         = r0_r;
    r1_nxt         = r1_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    ex_nxt         = ex_r;
    base_nxt       = base_r;
    res_nxt        = res_r;
    kind_nxt       = kind_r;
    err_nxt        = err_r;
    out_result_nxt = out_result_r;
    out_err_nxt    = out_err_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          base_nxt  = W'(in_data_word);
          err_nxt   = 1'b0;
          res_nxt   = '0;
          state_nxt = S_N_GO;
        end
      end
      S_N_GO: begin
        // n = p*q, plain shift-add
        acc_nxt   = '0;
        opa_nxt   = W'(p_r);
        opb_nxt   = W'(q_r);
        cnt_nxt   = CW'(W);
        ph_nxt    = 1'b0;
        plain_nxt = 1'b1;
        ret_nxt   = S_N_END;
        state_nxt = S_MUL;
      end
      S_N_END: begin
        n_nxt     = acc_r;
        acc_nxt   = '0;
        opa_nxt   = W'(pm);
        opb_nxt   = W'(qm);
        cnt_nxt   = CW'(W);
        ph_nxt    = 1'b0;
        plain_nxt = 1'b1;
        ret_nxt   = S_PHI_END;
        state_nxt = S_MUL;
      end
      S_PHI_END: begin
        phi_nxt = acc_r;
        if (kind_r == rmc_pkg::KIND_DECRYPT) begin
          if (acc_r == '0) begin
            err_nxt   = 1'b1;
            res_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            // e mod phi
            acc_nxt   = '0;
            opb_nxt   = W'(e_r);
            md_nxt    = acc_r;
            cnt_nxt   = CW'(W);
            ret_nxt   = S_EMOD_END;
            state_nxt = S_DIV;
          end
        end else begin
          ex_nxt    = W'(e_r);
          state_nxt = S_RED;
        end
      end
      S_EMOD_END: begin
        r0_nxt    = phi_r;
        r1_nxt    = acc_r;
        t0_nxt    = '0;
        t1_nxt    = (phi_r == W'(1)) ? '0 : W'(1);
        state_nxt = S_EU_TEST;
      end
      S_EU_TEST: begin
        if (r1_r == '0) begin
          if (r0_r == W'(1)) begin
            ex_nxt    = t0_r;
            state_nxt = S_RED;
          end else begin
            err_nxt   = 1'b1;
            res_nxt   = '0;
            state_nxt = S_FIN;
          end
        end else begin
          acc_nxt   = '0;
          opb_nxt   = r0_r;
          md_nxt    = r1_r;
          cnt_nxt   = CW'(W);
          ret_nxt   = S_EU_Q;
          state_nxt = S_DIV;
        end
      end
      S_EU_Q: begin
        r0_nxt    = r1_r;
        r1_nxt    = acc_r;
        // q*t1 mod phi, walking the bits of q
        acc_nxt   = '0;
        opa_nxt   = t1_r;
        opb_nxt   = quo_r;
        md_nxt    = phi_r;
        cnt_nxt   = CW'(W);
        ph_nxt    = 1'b0;
        plain_nxt = 1'b0;
        ret_nxt   = S_EU_T;
        state_nxt = S_MUL;
      end
      S_EU_T: begin
        t0_nxt    = t1_r;
        t1_nxt    = alu_res;
        state_nxt = S_EU_TEST;
      end
      S_RED: begin
        if (n_r == '0) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          acc_nxt   = '0;
          opb_nxt   = base_r;
          md_nxt    = n_r;
          cnt_nxt   = CW'(W);
          ret_nxt   = S_RED_END;
          state_nxt = S_DIV;
        end
      end
      S_RED_END: begin
        base_nxt  = acc_r;
        res_nxt   = (n_r == W'(1)) ? '0 : W'(1);
        ecnt_nxt  = CW'(W);
        state_nxt = S_PW_SQ;
      end
      S_PW_SQ: begin
        acc_nxt   = '0;
        opa_nxt   = res_r;
        opb_nxt   = res_r;
        md_nxt    = n_r;
        cnt_nxt   = CW'(W);
        ph_nxt    = 1'b0;
        plain_nxt = 1'b0;
        ret_nxt   = S_PW_SQ_END;
        state_nxt = S_MUL;
      end
      S_PW_SQ_END: begin
        res_nxt = acc_r;
        if (ex_r[W-1]) begin
          acc_nxt   = '0;
          opa_nxt   = base_r;
          opb_nxt   = acc_r;
          cnt_nxt   = CW'(W);
          ph_nxt    = 1'b0;
          ret_nxt   = S_PW_MUL_END;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_PW_NEXT;
        end
      end
      S_PW_MUL_END: begin
        res_nxt   = acc_r;
        state_nxt = S_PW_NEXT;
      end
      S_PW_NEXT: begin
        ex_nxt   = ex_r << 1;
        ecnt_nxt = ecnt_r - CW'(1);
        if (ecnt_r == CW'(1)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PW_SQ;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = res_r[31:0];
          out_err_nxt    = err_r;
          state_nxt      = S_IDLE;
        end
      end
      S_MUL: begin
        // Horner step: double, then add opa when the multiplier bit is set
        acc_nxt = alu_res;
        if (!ph_r && opb_r[W-1]) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt  = 1'b0;
          opb_nxt = opb_r << 1;
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = ret_r;
          end
        end
      end
      S_DIV: begin
        // restoring division step, remainder in acc
        acc_nxt = alu_res;
        quo_nxt = {quo_r[W-2:0], alu_ge};
        opb_nxt = opb_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_r         <= PRIME_BITS'(3);
      q_r         <= PRIME_BITS'(5);
      e_r         <= 32'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          rmc_pkg::CFG_FIRST_PRIME:     p_r <= cfg_data[PRIME_BITS-1:0];
          rmc_pkg::CFG_SECOND_PRIME:    q_r <= cfg_data[PRIME_BITS-1:0];
          rmc_pkg::CFG_PUBLIC_EXPONENT: e_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    cnt_r        <= cnt_nxt;
    ecnt_r       <= ecnt_nxt;
    ph_r         <= ph_nxt;
    plain_r      <= plain_nxt;
    acc_r        <= acc_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    md_r         <= md_nxt;
    quo_r        <= quo_nxt;
    n_r          <= n_nxt;
    phi_r        <= phi_nxt;
    r0_r         <= r0_nxt;
    r1_r         <= r1_nxt;
    t0_r         <= t0_nxt;
    t1_r         <= t1_nxt;
    ex_r         <= ex_nxt;
    base_r       <= base_nxt;
    res_r        <= res_nxt;
    kind_r       <= kind_nxt;
    err_r        <= err_nxt;
    out_result_r <= out_result_nxt;
    out_err_r    <= out_err_nxt;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_result_r == '0)
    else $error("key error with nonzero result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> md_r != '0)
    else $error("division by zero");

  a_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL && !plain_r |-> acc_r < md_r && opa_r < md_r)
    else $error("modular multiply operand out of range");

endmodule

// File: hw/rtl/rmc_alu.sv
module rmc_alu #(
  parameter int W = 32
) (
  input  logic [W-1:0]         x,
  input  logic [W-1:0]         y,
  input  logic [W-1:0]         m,
  input  rmc_pkg::rmc_alu_ctl_t ctl,
  output logic [W-1:0]         res,
  output logic                 ge
);

  logic [W-1:0] ysel;
  logic [W:0]   sum;
  logic [W:0]   diff;

  always_comb begin
    ysel = ctl.neg ? (m - y) : y;
    sum  = {1'b0, x} + {1'b0, ysel} + {{W{1'b0}}, ctl.cin};
    diff = sum - {1'b0, m};
    ge   = ctl.reduce && (sum >= {1'b0, m});
    res  = ge ? diff[W-1:0] : sum[W-1:0];
  end

endmodule
